// ----- sv/lphi_pkg.sv -----
// ----------------------------------------------------------------------------
// lphi_pkg: shared types and constants for the linear probing hash index
// Field structs, action and status codes, default sizes.
// ----------------------------------------------------------------------------
package lphi_pkg;

  localparam int unsigned SlotsDefault = 64;
  localparam int unsigned KeyW = 31;
  localparam int unsigned CfgW = 7;

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActSearch = 2'd1;
  localparam logic [1:0] ActDelete = 2'd2;
  localparam logic [1:0] ActNop    = 2'd3;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StFound    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StDeleted  = 3'd4;

  typedef struct packed {
    logic [1:0]      action;
    logic [KeyW-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot;
    logic [5:0] record_position;
  } rsp_t;

endpackage

// ----- sv/lphi_mod.sv -----
// ----------------------------------------------------------------------------
// lphi_mod: iterative key modulo unit
// Restoring division remainder of a key by the table size, one bit a cycle.
// ----------------------------------------------------------------------------
module lphi_mod
  import lphi_pkg::*;
#(
  parameter int unsigned AW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [AW:0]   div_i,
  output logic          done_o,
  output logic [AW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(KeyW + 1);

  logic [KeyW-1:0] sh_q;
  logic [AW+1:0]   rem_q;
  logic [AW:0]     div_q;
  logic [CW-1:0]   cnt_q;
  logic            run_q;
  logic [AW+1:0]   trial;

  assign trial  = {rem_q[AW:0], sh_q[KeyW-1]};
  assign done_o = run_q && (cnt_q == '0);
  assign rem_o  = rem_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (go_i) begin
      run_q <= 1'b1;
      cnt_q <= CW'(KeyW);
    end else if (run_q) begin
      if (cnt_q == '0) run_q <= 1'b0;
      else cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      sh_q  <= key_i;
      rem_q <= '0;
      div_q <= div_i;
    end else if (run_q && cnt_q != '0) begin
      sh_q <= {sh_q[KeyW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) rem_q <= trial - {1'b0, div_q};
      else rem_q <= trial;
    end
  end

endmodule

// ----- sv/lphi_ctrl.sv -----
// ----------------------------------------------------------------------------
// lphi_ctrl: command sequencer with slot table and record store
// Insert and rebuild after delete walk one slot per cycle; search walks slower.
// ----------------------------------------------------------------------------
module lphi_ctrl
  import lphi_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd_i,
  input  logic       cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output logic       done_o,
  output rsp_t       rsp_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned NW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_INS, S_SRD, S_SKEY, S_SCMP, S_DRD, S_DWR, S_CLR, S_RRD,
    S_RKEY, S_RMOD, S_RINS
  } state_e;

  state_e          state_q;
  logic [CfgW-1:0] tsize_q;
  logic [NW-1:0]   n;
  logic [SLOTS-1:0] valid_q;
  logic [AW-1:0]   stab [SLOTS];
  logic [KeyW-1:0] keys [SLOTS];
  logic [NW-1:0]   count_q;
  cmd_t            cmd_q;
  logic [AW-1:0]   idx_q;
  logic [NW-1:0]   step_q;
  logic [NW-1:0]   rd_q, wr_q;
  logic [KeyW-1:0] krd_q;
  logic [AW-1:0]   pos_q;
  logic            mgo;
  logic            mdone;
  logic [AW-1:0]   mrem;
  logic [KeyW-1:0] mkey;
  logic [AW-1:0]   idx_nx;

  always_comb begin
    if (tsize_q == '0) n = NW'(1);
    else if (32'(tsize_q) > SLOTS) n = NW'(SLOTS);
    else n = NW'(tsize_q);
  end

  assign idx_nx = ({1'b0, idx_q} + 1'b1 >= n) ? '0 : idx_q + 1'b1;
  assign busy   = (state_q != S_IDLE);
  assign mkey   = (state_q == S_IDLE) ? cmd_i.key : krd_q;
  assign mgo    = (start && !busy) || (state_q == S_RKEY);

  lphi_mod #(.AW(AW)) u_mod (
    .clk_i (clk_i), .rst_ni(rst_ni), .go_i(mgo), .key_i(mkey),
    .div_i (n), .done_o(mdone), .rem_o(mrem)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_SRD) pos_q <= stab[idx_q];
    if (state_q == S_DRD || state_q == S_RRD) krd_q <= keys[rd_q[AW-1:0]];
    if (state_q == S_SKEY) krd_q <= keys[pos_q];
    if (state_q == S_DWR && krd_q != cmd_q.key) keys[wr_q[AW-1:0]] <= krd_q;
    if (state_q == S_INS && !valid_q[idx_q] && cmd_q.action == ActInsert)
      keys[count_q[AW-1:0]] <= cmd_q.key;
    if ((state_q == S_INS || state_q == S_RINS) && !valid_q[idx_q])
      stab[idx_q] <= (state_q == S_INS) ? count_q[AW-1:0] : rd_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tsize_q <= CfgW'(SlotsDefault);
      valid_q <= '0;
      count_q <= '0;
      done_o  <= 1'b0;
      rsp_o   <= '0;
      cmd_q   <= '0;
      idx_q   <= '0;
      step_q  <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            tsize_q <= cfg_wdata_i;
            valid_q <= '0;
            count_q <= '0;
          end else if (start) begin
            cmd_q   <= cmd_i;
            step_q  <= '0;
            if (cmd_i.action == ActDelete) begin
              rd_q <= '0; wr_q <= '0;
              state_q <= S_DRD;
            end else if (cmd_i.action == ActInsert && count_q >= NW'(SLOTS)) begin
              done_o <= 1'b1; rsp_o <= '{StFull, 6'd0, 6'd0};
            end else if (cmd_i.action == ActInsert || cmd_i.action == ActSearch) begin
              state_q <= S_MOD;
            end else begin
              done_o <= 1'b1; rsp_o <= '{StNotFound, 6'd0, 6'd0};
            end
          end
        end
        S_MOD: if (mdone) begin
          idx_q   <= mrem;
          state_q <= (cmd_q.action == ActInsert) ? S_INS : S_SRD;
        end
        S_INS: begin
          if (!valid_q[idx_q]) begin
            valid_q[idx_q] <= 1'b1;
            done_o  <= 1'b1;
            rsp_o   <= '{StInserted, 6'(idx_q), 6'(count_q)};
            count_q <= count_q + 1'b1;
            state_q <= S_IDLE;
          end else if (step_q + 1'b1 >= n) begin
            done_o <= 1'b1; rsp_o <= '{StFull, 6'd0, 6'd0};
            state_q <= S_IDLE;
          end else begin
            step_q <= step_q + 1'b1; idx_q <= idx_nx;
          end
        end
        S_SRD: state_q <= S_SKEY;
        S_SKEY: state_q <= S_SCMP;
        S_SCMP: begin
          if (valid_q[idx_q] && {1'b0, pos_q} < count_q && krd_q == cmd_q.key) begin
            done_o <= 1'b1; rsp_o <= '{StFound, 6'(idx_q), 6'(pos_q)};
            state_q <= S_IDLE;
          end else if (step_q + 1'b1 >= n) begin
            done_o <= 1'b1; rsp_o <= '{StNotFound, 6'd0, 6'd0};
            state_q <= S_IDLE;
          end else begin
            step_q <= step_q + 1'b1; idx_q <= idx_nx; state_q <= S_SRD;
          end
        end
        S_DRD: begin
          if (rd_q >= count_q) begin
            count_q <= wr_q; valid_q <= '0; rd_q <= '0; state_q <= S_RRD;
          end else state_q <= S_DWR;
        end
        S_DWR: begin
          if (krd_q != cmd_q.key) wr_q <= wr_q + 1'b1;
          rd_q <= rd_q + 1'b1; state_q <= S_DRD;
        end
        S_RRD: begin
          if (rd_q >= count_q) begin
            done_o <= 1'b1; rsp_o <= '{StDeleted, 6'd0, 6'd0};
            state_q <= S_IDLE;
          end else begin
            step_q <= '0; state_q <= S_RKEY;
          end
        end
        S_RKEY: state_q <= S_RMOD;
        S_RMOD: if (mdone) begin
          idx_q <= mrem; state_q <= S_RINS;
        end
        S_RINS: begin
          if (!valid_q[idx_q] || step_q + 1'b1 >= n) begin
            if (!valid_q[idx_q]) valid_q[idx_q] <= 1'b1;
            rd_q <= rd_q + 1'b1; state_q <= S_RRD;
          end else begin
            step_q <= step_q + 1'b1; idx_q <= idx_nx;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/linear_probe_hash_index.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_index: open addressing hash index with linear probing
//
// Channel   Direction  Handshake          Payload
// command   in         start & !busy      cmd_i  (action, key)
// result    out        done_o strobe      rsp_o  (status, slot, record_position)
// config    in         cfg_we_i           cfg_wdata_i (table_size)
//
// Steps: the home slot comes from the bit-serial modulo unit; an insert then
// probes one slot a cycle from there and strobes its result on the first free
// slot, else Full; a search reads each slot through S_SRD, S_SKEY and S_SCMP.
// Delete first compacts the record store, reading each record and writing the
// kept ones, then for each kept record reruns the modulo unit and probes for a free slot.
// Reset empties the slot table and the record store. The receiver cannot
// stall; busy holds off new commands until the result strobe.
// ----------------------------------------------------------------------------
module linear_probe_hash_index
  import lphi_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  cmd_t            cmd_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output logic            done_o,
  output rsp_t            rsp_o
);

  lphi_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(busy) |-> !busy) else $error("result while still busy");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.status <= StDeleted) else $error("bad status");
  a_noslot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == StFull || rsp_o.status == StDeleted) |-> rsp_o.slot == '0)
    else $error("slot set on no-slot status");

endmodule

// ----- verif/linear_probe_hash_index_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_index_tb: self-checking bench for the hash index
// Issues directed and random insert, search and delete commands across
// several table sizes, predicts every response and compares field by field.
// ----------------------------------------------------------------------------
module linear_probe_hash_index_tb;
  import lphi_pkg::*;

  localparam int unsigned NSLOTS = 64;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;
  logic done_o;
  rsp_t rsp_o;

  linear_probe_hash_index #(.SLOTS(NSLOTS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  // predictor state
  int unsigned size_reg;
  bit          hslot_valid [NSLOTS];
  int unsigned hslot_pos   [NSLOTS];
  logic [KeyW-1:0] stored_keys [NSLOTS];
  int unsigned stored_count;

  rsp_t expected_rsps[$];
  int unsigned mismatches;
  int unsigned responses_checked;
  int unsigned found_seen;
  int unsigned full_seen;
  logic [KeyW-1:0] key_pool[$];

  typedef struct {
    logic [1:0]      action;
    logic [KeyW-1:0] key;
    bit              has_exp;
    logic [2:0]      status;
    logic [5:0]      slot;
    logic [5:0]      pos;
  } vec_t;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2s;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned active_size();
    int unsigned n;
    n = size_reg;
    if (n == 0) n = 1;
    if (n > NSLOTS) n = NSLOTS;
    return n;
  endfunction

  function automatic int place_record(logic [KeyW-1:0] k, int unsigned p);
    int unsigned n;
    int unsigned idx;
    n = active_size();
    idx = k % n;
    for (int unsigned i = 0; i < n; i++) begin
      if (!hslot_valid[idx]) begin
        hslot_valid[idx] = 1'b1;
        hslot_pos[idx] = p;
        return idx;
      end
      idx = (idx + 1 >= n) ? 0 : idx + 1;
    end
    return -1;
  endfunction

  function automatic void clear_index();
    foreach (hslot_valid[i]) begin
      hslot_valid[i] = 1'b0;
      hslot_pos[i] = 0;
    end
  endfunction

  function automatic rsp_t predict_response(cmd_t c);
    rsp_t r;
    int s;
    int unsigned n;
    int unsigned idx;
    int unsigned w;
    r = '{status: StNotFound, slot: '0, record_position: '0};
    n = active_size();
    case (c.action)
      ActInsert: begin
        r.status = StFull;
        if (stored_count < NSLOTS) begin
          s = place_record(c.key, stored_count);
          if (s >= 0) begin
            stored_keys[stored_count] = c.key;
            r = '{status: StInserted, slot: s[5:0], record_position: stored_count[5:0]};
            stored_count++;
          end
        end
      end
      ActSearch: begin
        idx = c.key % n;
        for (int unsigned i = 0; i < n; i++) begin
          if (hslot_valid[idx] && hslot_pos[idx] < stored_count &&
              stored_keys[hslot_pos[idx]] == c.key) begin
            r = '{status: StFound, slot: idx[5:0], record_position: hslot_pos[idx][5:0]};
            break;
          end
          idx = (idx + 1 >= n) ? 0 : idx + 1;
        end
      end
      ActDelete: begin
        w = 0;
        for (int unsigned i = 0; i < stored_count; i++) begin
          if (stored_keys[i] != c.key) begin
            stored_keys[w] = stored_keys[i];
            w++;
          end
        end
        stored_count = w;
        clear_index();
        for (int unsigned i = 0; i < stored_count; i++) s = place_record(stored_keys[i], i);
        r.status = StDeleted;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && done_o) begin
      responses_checked++;
      if (rsp_o.status == StFound) found_seen++;
      if (rsp_o.status == StFull) full_seen++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp_o);
      end else begin
        e = expected_rsps.pop_front();
        if (rsp_o.status !== e.status || rsp_o.slot !== e.slot ||
            rsp_o.record_position !== e.record_position) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, rsp_o);
        end
      end
    end
  end

  task automatic idle_cycles();
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(posedge clk_i);
  endtask

  task automatic issue_cmd(logic [1:0] a, logic [KeyW-1:0] k);
    cmd_t c;
    c.action = a;
    c.key = k;
    cmd_i <= c;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_rsps = {expected_rsps, predict_response(c)};
    start <= 1'b0;
    cmd_i <= {2'($urandom()), KeyW'($urandom())};
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_size(int unsigned v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[CfgW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = v & 7'h7f;
    clear_index();
    stored_count = 0;
    key_pool.delete();
  endtask

  function automatic logic [KeyW-1:0] pick_key(int unsigned n);
    if (key_pool.size() != 0 && $urandom_range(0, 2) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    case ($urandom_range(0, 3))
      0: return KeyW'($urandom_range(0, 3 * n));
      1: return KeyW'($urandom());
      2: return KeyW'({KeyW{1'b1}} - $urandom_range(0, 3));
      default: return KeyW'($urandom_range(0, 7) * n + $urandom_range(0, 1));
    endcase
  endfunction

  task automatic random_phase(int unsigned count);
    logic [1:0] a;
    logic [KeyW-1:0] k;
    int unsigned n;
    n = active_size();
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: a = ActInsert;
        8, 9, 10, 11, 12, 13, 14, 15: a = ActSearch;
        19: a = ActNop;
        default: a = ActDelete;
      endcase
      k = pick_key(n);
      if (a == ActInsert) key_pool = {key_pool, k};
      issue_cmd(a, k);
      idle_cycles();
    end
  endtask

  vec_t directed[$];
  rsp_t e;

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    mismatches = 0;
    responses_checked = 0;
    found_seen = 0;
    full_seen = 0;
    size_reg = 64;
    clear_index();
    stored_count = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      '{ActSearch, 31'd5,          1, StNotFound, 6'd0,  6'd0},
      '{ActInsert, 31'd0,          1, StInserted, 6'd0,  6'd0},
      '{ActInsert, 31'h7fffffff,   1, StInserted, 6'd63, 6'd1},
      '{ActInsert, 31'd64,         1, StInserted, 6'd1,  6'd2},
      '{ActInsert, 31'd63,         1, StInserted, 6'd2,  6'd3},
      '{ActSearch, 31'd64,         1, StFound,    6'd1,  6'd2},
      '{ActSearch, 31'h7fffffff,   1, StFound,    6'd63, 6'd1},
      '{ActInsert, 31'd0,          0, 0, 0, 0},
      '{ActSearch, 31'd0,          0, 0, 0, 0},
      '{ActNop,    31'd0,          1, StNotFound, 6'd0,  6'd0},
      '{ActDelete, 31'd0,          1, StDeleted,  6'd0,  6'd0},
      '{ActSearch, 31'd64,         0, 0, 0, 0},
      '{ActDelete, 31'd12345,      1, StDeleted,  6'd0,  6'd0},
      '{ActSearch, 31'd0,          1, StNotFound, 6'd0,  6'd0},
      '{ActInsert, 31'h2aaaaaaa,   0, 0, 0, 0},
      '{ActInsert, 31'h55555555,   0, 0, 0, 0},
      '{ActSearch, 31'h55555555,   0, 0, 0, 0}
    };
    foreach (directed[i]) begin
      issue_cmd(directed[i].action, directed[i].key);
      if (directed[i].has_exp) begin
        e = '{status: directed[i].status, slot: directed[i].slot,
              record_position: directed[i].pos};
        if (e != expected_rsps[$]) begin
          mismatches++;
          if (mismatches <= 10) $display("directed row %0d: table %p, predictor %p",
                                         i, e, expected_rsps[$]);
        end
      end
      idle_cycles();
    end

    // size 1 fills at once; size 0 acts as 1; oversized saturates
    set_size(1);
    issue_cmd(ActInsert, 31'd9);
    issue_cmd(ActInsert, 31'd9);
    issue_cmd(ActSearch, 31'd9);
    issue_cmd(ActDelete, 31'd9);
    issue_cmd(ActInsert, 31'd7);
    set_size(0);
    issue_cmd(ActInsert, 31'h7fffffff);
    issue_cmd(ActInsert, 31'd3);
    set_size(127);
    random_phase(300);
    set_size(3);
    random_phase(250);
    set_size(64);
    random_phase(600);
    set_size(8);
    random_phase(250);
    set_size(37);
    random_phase(400);

    drain();
    $display("checked %0d responses (%0d found, %0d full) over sizes 0..127",
             responses_checked, found_seen, full_seen);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lphi_pkg.sv
sv/lphi_mod.sv
sv/lphi_ctrl.sv
sv/linear_probe_hash_index.sv
verif/linear_probe_hash_index_tb.sv
